>>> sv/mpool_pkg.sv
// shared constants for the max pooling window core
package mpool_pkg;

  // default plane side and fixed limits
  localparam int unsigned MAX_DIM_DEF = 128;
  localparam int unsigned MAX_KERNEL  = 16;
  localparam int unsigned PAD_LIMIT   = 16;
  localparam int unsigned STRIDE_LIMIT = 16;
  localparam int unsigned SAMPLE_BITS = 16;

  // configuration register indexes
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_KERNEL_SIZE  = 3'd2;
  localparam logic [2:0] REG_PAD_AMOUNT   = 3'd3;
  localparam logic [2:0] REG_STRIDE_STEP  = 3'd4;

  // register reset values
  localparam logic [7:0] HEIGHT_RST = 8'd128;
  localparam logic [7:0] WIDTH_RST  = 8'd128;
  localparam logic [4:0] KERNEL_RST = 5'd5;
  localparam logic [4:0] PAD_RST    = 5'd2;
  localparam logic [4:0] STRIDE_RST = 5'd2;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ALL_PAD     = 2'd1;
  localparam logic [1:0] STATUS_OUT_OF_GRID = 2'd2;

  // most negative sample, returned when no position is valid
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // query sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_CHECK = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

endpackage

>>> sv/max_pool_2d_window_core.sv
// max pooling core: image plane store, window scan and max reduction
//
//  channel   signals                                     direction  transfer when
//  request   start busy req_type row_pos col_pos         in         start && !busy
//            sample_value
//  result    done max_value status_code                  out        done (one cycle)
//  config    cfg_write cfg_index cfg_data                in         cfg_write
//
//  a sample write is stored at the edge that takes it; busy stays low, so a new
//  request can follow in the next cycle
//  a pool query steps through multiply, grid check, a scan of one window position
//  per cycle (padded positions included, with one read of the store read port for
//  each position on the plane), drain and finish before done
//  a query outside the grid answers from the grid check, without a scan
//  reset (rst, synchronous) restores the register defaults; the store is not
//  cleared, entries read back undefined until written
//  the result side cannot stall: done is a one-cycle strobe
module max_pool_2d_window_core #(
  parameter int unsigned MAX_DIM = mpool_pkg::MAX_DIM_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // request
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    req_type,
  input  logic [7:0]                              row_pos,
  input  logic [7:0]                              col_pos,
  input  logic signed [mpool_pkg::SAMPLE_BITS-1:0] sample_value,
  // result
  output logic                                    done,
  output logic signed [mpool_pkg::SAMPLE_BITS-1:0] max_value,
  output logic [1:0]                              status_code,
  // configuration
  input  logic                                    cfg_write,
  input  logic [2:0]                              cfg_index,
  input  logic [7:0]                              cfg_data
);

  localparam int unsigned SB     = mpool_pkg::SAMPLE_BITS;
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ROW_W  = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // configuration registers, raw as written
  logic [7:0] image_height;
  logic [7:0] image_width;
  logic [4:0] kernel_size;
  logic [4:0] pad_amount;
  logic [4:0] stride_step;

  // clamped working values
  logic [7:0] hh;
  logic [7:0] ww;
  logic [4:0] kk;
  logic [4:0] pd;
  logic [4:0] st;

  // sequencer
  mpool_pkg::state_t state;
  logic [7:0]  q_row;
  logic [7:0]  q_col;
  logic [12:0] prod_r;
  logic [12:0] prod_c;
  logic signed [10:0] span_h;
  logic signed [10:0] span_w;
  logic        in_grid;

  // window walk: bit 13 of the positions is the sign
  logic [13:0] r_cur;
  logic [13:0] c_cur;
  logic [13:0] c_base;
  logic [3:0]  i_cnt;
  logic [3:0]  j_cnt;
  logic        j_last;
  logic        i_last;
  logic        pos_ok;

  // plane store ports
  logic signed [SB-1:0] mem [DEPTH];
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic signed [SB-1:0] rd_data;
  logic                 rd_pend;

  // running max
  logic signed [SB-1:0] best;
  logic                 any;

  // ---------------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= mpool_pkg::HEIGHT_RST;
      image_width  <= mpool_pkg::WIDTH_RST;
      kernel_size  <= mpool_pkg::KERNEL_RST;
      pad_amount   <= mpool_pkg::PAD_RST;
      stride_step  <= mpool_pkg::STRIDE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mpool_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        mpool_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        mpool_pkg::REG_KERNEL_SIZE:  kernel_size  <= cfg_data[4:0];
        mpool_pkg::REG_PAD_AMOUNT:   pad_amount   <= cfg_data[4:0];
        mpool_pkg::REG_STRIDE_STEP:  stride_step  <= cfg_data[4:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // clamp every register into its legal range on use
  always_comb begin
    if (image_height == 8'd0)                  hh = 8'd1;
    else if (32'(image_height) > 32'(MAX_DIM)) hh = 8'(MAX_DIM);
    else                                       hh = image_height;

    if (image_width == 8'd0)                   ww = 8'd1;
    else if (32'(image_width) > 32'(MAX_DIM))  ww = 8'(MAX_DIM);
    else                                       ww = image_width;

    if (kernel_size == 5'd0) kk = 5'd1;
    else if (32'(kernel_size) > 32'(mpool_pkg::MAX_KERNEL))
      kk = 5'(mpool_pkg::MAX_KERNEL);
    else kk = kernel_size;

    if (32'(pad_amount) > 32'(mpool_pkg::PAD_LIMIT)) pd = 5'(mpool_pkg::PAD_LIMIT);
    else                                              pd = pad_amount;

    if (stride_step == 5'd0) st = 5'd1;
    else if (32'(stride_step) > 32'(mpool_pkg::STRIDE_LIMIT))
      st = 5'(mpool_pkg::STRIDE_LIMIT);
    else st = stride_step;
  end

  // ---------------------------------------------------------------------------
  // grid check without a divider: row < span/st + 1  <=>  row*st <= span
  assign span_h  = 11'(hh) - 11'(kk) + 11'({pd, 1'b0});
  assign span_w  = 11'(ww) - 11'(kk) + 11'({pd, 1'b0});
  assign in_grid = !span_h[10] && !span_w[10]
                && (prod_r <= 13'($unsigned(span_h)))
                && (prod_c <= 13'($unsigned(span_w)));

  // current window position lies inside the plane
  assign pos_ok = !r_cur[13] && (r_cur < 14'(hh))
               && !c_cur[13] && (c_cur < 14'(ww));

  assign j_last = ({1'b0, j_cnt} == (kk - 5'd1));
  assign i_last = ({1'b0, i_cnt} == (kk - 5'd1));

  assign busy = (state != mpool_pkg::S_IDLE);

  // ---------------------------------------------------------------------------
  // store addressing; rows and columns are in range whenever the port is enabled
  assign wr_en   = start && !busy && (req_type == mpool_pkg::REQ_WRITE)
                && (row_pos < hh) && (col_pos < ww);
  assign wr_addr = ADDR_W'(ADDR_W'(ROW_W'(row_pos)) * ADDR_W'(MAX_DIM))
                 + ADDR_W'(ROW_W'(col_pos));
  assign rd_en   = (state == mpool_pkg::S_SCAN) && pos_ok;
  assign rd_addr = ADDR_W'(ADDR_W'(ROW_W'(r_cur)) * ADDR_W'(MAX_DIM))
                 + ADDR_W'(ROW_W'(c_cur));

  // plane store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sample_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mpool_pkg::S_IDLE;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= rd_en;
      unique case (state)
        mpool_pkg::S_IDLE: begin
          if (start && req_type == mpool_pkg::REQ_QUERY) begin
            state <= mpool_pkg::S_MUL;
          end
        end
        mpool_pkg::S_MUL: begin
          state <= mpool_pkg::S_CHECK;
        end
        mpool_pkg::S_CHECK: begin
          if (in_grid) begin
            state <= mpool_pkg::S_SCAN;
          end else begin
            done  <= 1'b1;
            state <= mpool_pkg::S_IDLE;
          end
        end
        mpool_pkg::S_SCAN: begin
          if (j_last && i_last) begin
            state <= mpool_pkg::S_DRAIN;
          end
        end
        mpool_pkg::S_DRAIN: begin
          state <= mpool_pkg::S_FIN;
        end
        mpool_pkg::S_FIN: begin
          done  <= 1'b1;
          state <= mpool_pkg::S_IDLE;
        end
        default: state <= mpool_pkg::S_IDLE;
      endcase
    end
  end

  // datapath: coordinates, window walk, running max and result
  always_ff @(posedge clk) begin
    case (state)
      mpool_pkg::S_IDLE: begin
        q_row <= row_pos;
        q_col <= col_pos;
      end
      mpool_pkg::S_MUL: begin
        prod_r <= 13'(q_row * st);
        prod_c <= 13'(q_col * st);
      end
      mpool_pkg::S_CHECK: begin
        // window origin is coordinate*stride - padding
        r_cur  <= 14'(prod_r) - 14'(pd);
        c_cur  <= 14'(prod_c) - 14'(pd);
        c_base <= 14'(prod_c) - 14'(pd);
        i_cnt  <= 4'd0;
        j_cnt  <= 4'd0;
        any    <= 1'b0;
        best   <= mpool_pkg::SAMPLE_MIN;
        if (!in_grid) begin
          max_value   <= mpool_pkg::SAMPLE_MIN;
          status_code <= mpool_pkg::STATUS_OUT_OF_GRID;
        end
      end
      mpool_pkg::S_SCAN: begin
        if (j_last) begin
          j_cnt <= 4'd0;
          c_cur <= c_base;
          i_cnt <= i_cnt + 4'd1;
          r_cur <= r_cur + 14'd1;
        end else begin
          j_cnt <= j_cnt + 4'd1;
          c_cur <= c_cur + 14'd1;
        end
      end
      mpool_pkg::S_FIN: begin
        max_value   <= any ? best : mpool_pkg::SAMPLE_MIN;
        status_code <= any ? mpool_pkg::STATUS_OK : mpool_pkg::STATUS_ALL_PAD;
      end
      default: ;
    endcase

    // fold in read data in the cycle after its address
    if (rd_pend && (state == mpool_pkg::S_SCAN || state == mpool_pkg::S_DRAIN)) begin
      if (!any || rd_data > best) begin
        best <= rd_data;
      end
      any <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == mpool_pkg::S_FIN || state == mpool_pkg::S_CHECK))
    else $error("result strobe without a finishing query");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state == mpool_pkg::S_SCAN))
    else $error("store read data outside a window scan");

  a_grid_value: assert property (@(posedge clk) disable iff (rst)
    done && status_code == mpool_pkg::STATUS_OUT_OF_GRID
      |-> max_value == mpool_pkg::SAMPLE_MIN)
    else $error("out-of-grid result carries a sample value");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && req_type == mpool_pkg::REQ_QUERY))
    else $error("sequencer left idle without a query transfer");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("store written during a query");

endmodule

>>> test/pool_result_checker.sv
// checker for the max pooling core: mirrors plane and registers, predicts and compares results
`timescale 1ns / 100ps

module pool_result_checker
  import mpool_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          req_type,
  input  logic [7:0]                    row_pos,
  input  logic [7:0]                    col_pos,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          done,
  input  logic signed [SAMPLE_BITS-1:0] max_value,
  input  logic [1:0]                    status_code,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [7:0]                    cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   outstanding
);

  localparam int PLANE_DIM = MAX_DIM_DEF;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] peak;
    logic [1:0]                    status;
  } pool_result_t;

  pool_result_t                  pending_results[$];
  logic signed [SAMPLE_BITS-1:0] plane_copy[0:PLANE_DIM*PLANE_DIM-1];
  logic [7:0]                    height_reg;
  logic [7:0]                    width_reg;
  logic [4:0]                    kernel_reg;
  logic [4:0]                    pad_reg;
  logic [4:0]                    stride_reg;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int grid_len(int dim, int k, int pad, int st);
    int span;
    span = dim - k + 2 * pad;
    if (span < 0) return 0;
    return span / st + 1;
  endfunction

  // max over the window of output (row, col), padded positions skipped
  function automatic pool_result_t pool_window(int row, int col);
    int           h, w, k, p, s, r0, c0, r, c, best;
    bit           any;
    pool_result_t res;
    h    = clamp_to(height_reg, 1, PLANE_DIM);
    w    = clamp_to(width_reg, 1, PLANE_DIM);
    k    = clamp_to(kernel_reg, 1, MAX_KERNEL);
    p    = clamp_to(pad_reg, 0, PAD_LIMIT);
    s    = clamp_to(stride_reg, 1, STRIDE_LIMIT);
    best = SAMPLE_MIN;
    any  = 1'b0;
    if (row >= grid_len(h, k, p, s) || col >= grid_len(w, k, p, s)) begin
      res.peak   = SAMPLE_MIN;
      res.status = STATUS_OUT_OF_GRID;
      return res;
    end
    r0 = row * s - p;
    c0 = col * s - p;
    for (int i = 0; i < k; i++) begin
      r = r0 + i;
      if (r < 0 || r >= h) continue;
      for (int j = 0; j < k; j++) begin
        c = c0 + j;
        if (c < 0 || c >= w) continue;
        if (!any || int'(plane_copy[r*PLANE_DIM+c]) > best) best = plane_copy[r*PLANE_DIM+c];
        any = 1'b1;
      end
    end
    res.peak   = any ? SAMPLE_BITS'(best) : SAMPLE_MIN;
    res.status = any ? STATUS_OK : STATUS_ALL_PAD;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t pool check: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    int           h, w;
    if (rst) begin
      height_reg = HEIGHT_RST;
      width_reg  = WIDTH_RST;
      kernel_reg = KERNEL_RST;
      pad_reg    = PAD_RST;
      stride_reg = STRIDE_RST;
      pending_results.delete();
    end else begin
      // results first: a result never belongs to a query taken at the same edge
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no query pending (max %0d status %0d)",
                                    max_value, status_code));
        end else begin
          want = pending_results.pop_front();
          if (max_value !== want.peak)
            report_mismatch($sformatf("max_value %0d, expected %0d", max_value, want.peak));
          if (status_code !== want.status)
            report_mismatch($sformatf("status_code %0d, expected %0d", status_code,
                                      want.status));
        end
      end
      if (start && !busy) begin
        if (req_type == REQ_WRITE) begin
          h = clamp_to(height_reg, 1, PLANE_DIM);
          w = clamp_to(width_reg, 1, PLANE_DIM);
          if (row_pos < h && col_pos < w) plane_copy[row_pos*PLANE_DIM+col_pos] = sample_value;
        end else begin
          pending_results.push_back(pool_window(row_pos, col_pos));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          REG_KERNEL_SIZE:  kernel_reg = cfg_data[4:0];
          REG_PAD_AMOUNT:   pad_reg    = cfg_data[4:0];
          REG_STRIDE_STEP:  stride_reg = cfg_data[4:0];
          default: ;
        endcase
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

>>> test/tb.sv
// testbench top for the max pooling core: stimulus, timeout and verdict
`timescale 1ns / 100ps

module tb;
  import mpool_pkg::*;

  localparam int PLANE_DIM       = MAX_DIM_DEF;
  // limit on run length, set with room to spare above the slowest run
  localparam int CYCLE_LIMIT     = 1_500_000;
  // tail after the drain: covers the longest query, a full 16x16 window, with margin
  localparam int TAIL_CYCLES     = MAX_KERNEL * MAX_KERNEL + 8;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 50;
  // indexes past the last register, written to check they are ignored
  localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          start        = 1'b0;
  logic                          req_type     = REQ_WRITE;
  logic [7:0]                    row_pos      = '0;
  logic [7:0]                    col_pos      = '0;
  logic signed [SAMPLE_BITS-1:0] sample_value = '0;
  logic                          cfg_write    = 1'b0;
  logic [2:0]                    cfg_index    = REG_IMAGE_HEIGHT;
  logic [7:0]                    cfg_data     = '0;
  logic                          busy;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [1:0]                    status_code;
  int unsigned                   fail_count;
  int unsigned                   outstanding;

  // register values as last written, raw (clamping happens on use)
  logic [7:0] height_cfg = HEIGHT_RST;
  logic [7:0] width_cfg  = WIDTH_RST;
  logic [4:0] kernel_cfg = KERNEL_RST;
  logic [4:0] pad_cfg    = PAD_RST;
  logic [4:0] stride_cfg = STRIDE_RST;

  // plane entries that hold a sample; the store powers up undefined, so no query
  // window may ever cover an entry left unmarked here
  bit sample_written[0:PLANE_DIM*PLANE_DIM-1];

  // items left in the current back-to-back burst before the next gap
  int burst_left = 0;
  int cycle_count = 0;

  max_pool_2d_window_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .row_pos      (row_pos),
    .col_pos      (col_pos),
    .sample_value (sample_value),
    .done         (done),
    .max_value    (max_value),
    .status_code  (status_code),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pool_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .row_pos      (row_pos),
    .col_pos      (col_pos),
    .sample_value (sample_value),
    .done         (done),
    .max_value    (max_value),
    .status_code  (status_code),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop if the core hangs or loses a result
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int grid_len(int dim, int k, int pad, int st);
    int span;
    span = dim - k + 2 * pad;
    if (span < 0) return 0;
    return span / st + 1;
  endfunction

  // effective plane and grid shape under the current registers
  task automatic plane_geometry(output int h, output int w, output int k, output int p,
                                output int s, output int rows, output int cols);
    h    = clamp_to(height_cfg, 1, PLANE_DIM);
    w    = clamp_to(width_cfg, 1, PLANE_DIM);
    k    = clamp_to(kernel_cfg, 1, MAX_KERNEL);
    p    = clamp_to(pad_cfg, 0, PAD_LIMIT);
    s    = clamp_to(stride_cfg, 1, STRIDE_LIMIT);
    rows = grid_len(h, k, p, s);
    cols = grid_len(w, k, p, s);
  endtask

  // samples lean toward the two extremes so ties and sign handling get exercised
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MIN;
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // one request transfer; called right after a rising edge, returns right after the
  // edge that took it (or after the idle gap that follows a burst)
  task automatic send_item(logic kind, logic [7:0] row, logic [7:0] col,
                           logic signed [SAMPLE_BITS-1:0] value);
    int h, w, k, p, s, rows, cols, gap;
    start        <= 1'b1;
    req_type     <= kind;
    row_pos      <= row;
    col_pos      <= col;
    sample_value <= value;
    do @(posedge clk); while (busy);
    plane_geometry(h, w, k, p, s, rows, cols);
    // writes outside the plane are dropped by the core, so they mark nothing
    if (kind == REQ_WRITE && row < h && col < w) sample_written[row*PLANE_DIM+col] = 1'b1;
    // start stays high inside a burst; it only drops for the gap after one
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // write every plane entry the query window touches that has never been written
  task automatic fill_window(int row, int col);
    int h, w, k, p, s, rows, cols, r, c;
    plane_geometry(h, w, k, p, s, rows, cols);
    if (row >= rows || col >= cols) return;
    for (int i = 0; i < k; i++) begin
      r = row * s - p + i;
      if (r < 0 || r >= h) continue;
      for (int j = 0; j < k; j++) begin
        c = col * s - p + j;
        if (c < 0 || c >= w) continue;
        if (!sample_written[r*PLANE_DIM+c]) send_item(REQ_WRITE, 8'(r), 8'(c), pick_sample());
      end
    end
  endtask

  // every query goes through here, so no window ever reads an unwritten entry
  task automatic pool_query(logic [7:0] row, logic [7:0] col);
    fill_window(row, col);
    send_item(REQ_QUERY, row, col, SAMPLE_BITS'($urandom));
  endtask

  // drop start and wait until the core has answered everything and gone quiet
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    // writes land at their own edge; the idle tail below covers anything in flight
    repeat (4) @(posedge clk);
  endtask

  // cfg_write is left high between back-to-back writes; the caller lowers it
  task automatic set_reg(logic [2:0] idx, logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_IMAGE_HEIGHT: height_cfg = data;
      REG_IMAGE_WIDTH:  width_cfg  = data;
      REG_KERNEL_SIZE:  kernel_cfg = data[4:0];
      REG_PAD_AMOUNT:   pad_cfg    = data[4:0];
      REG_STRIDE_STEP:  stride_cfg = data[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] h, logic [7:0] w, logic [7:0] k, logic [7:0] p,
                           logic [7:0] s, bit poke_unused);
    wait_idle();
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_KERNEL_SIZE, k);
    set_reg(REG_PAD_AMOUNT, p);
    set_reg(REG_STRIDE_STEP, s);
    if (poke_unused)
      set_reg(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), 8'($urandom));
    cfg_write <= 1'b0;
  endtask

  // register picks: mostly small shapes, with the extremes and raw out-of-range values
  function automatic logic [7:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 8'd1;
      1:       return 8'(PLANE_DIM);
      2:       return 8'($urandom);
      default: return 8'($urandom_range(1, 20));
    endcase
  endfunction

  // 5-bit registers: upper data bits are junk the core must ignore
  function automatic logic [7:0] pick_field(int lo, int hi, int typical_hi);
    logic [4:0] v;
    case ($urandom_range(0, 9))
      0:       v = 5'(lo);
      1:       v = 5'(hi);
      2:       v = 5'($urandom);
      default: v = 5'($urandom_range(lo, typical_hi));
    endcase
    return {3'($urandom), v};
  endfunction

  // one random step of a phase
  task automatic random_action();
    int h, w, k, p, s, rows, cols, pick;
    plane_geometry(h, w, k, p, s, rows, cols);
    pick = $urandom_range(0, 99);
    if (pick < 55 && rows > 0 && cols > 0) begin
      // well-formed query inside the grid
      pool_query(8'($urandom_range(0, rows - 1)), 8'($urandom_range(0, cols - 1)));
    end else if (pick < 65) begin
      // just past the grid edge, or anywhere at all
      if ($urandom_range(0, 1))
        pool_query(8'(clamp_to(rows + $urandom_range(0, 2), 0, 255)), 8'($urandom_range(0, 255)));
      else
        pool_query(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      // overwrite inside the plane
      send_item(REQ_WRITE, 8'($urandom_range(0, h - 1)), 8'($urandom_range(0, w - 1)),
                pick_sample());
    end else begin
      // write at a random spot, usually off the plane and dropped
      send_item(REQ_WRITE, 8'($urandom), 8'($urandom), pick_sample());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset shape (128x128, kernel 5, pad 2, stride 2): 64x64 grid, nothing stored yet
    pool_query(8'hFF, 8'hFF);                       // far outside the grid
    pool_query(8'd64, 8'd0);                        // first row past the grid
    send_item(REQ_WRITE, 8'hFF, 8'h80, 16'sh7FFF);  // row off the plane, dropped
    send_item(REQ_WRITE, 8'd0, 8'hFF, 16'sh0001);   // column off the plane, dropped

    // 3x3 plane, kernel 2, pad 1, stride 1: 4x4 grid, corner windows mostly padding
    configure(8'd3, 8'd3, 8'd2, 8'd1, 8'd1, 1'b0);
    send_item(REQ_WRITE, 8'd0, 8'd0, SAMPLE_MIN);
    send_item(REQ_WRITE, 8'd1, 8'd1, 16'sh7FFF);
    send_item(REQ_WRITE, 8'd2, 8'd2, -16'sd1);
    pool_query(8'd0, 8'd0);                         // lone valid sample is the minimum
    pool_query(8'd3, 8'd3);
    pool_query(8'd1, 8'd1);
    pool_query(8'd0, 8'd4);                         // column past the grid

    // kernel 1 with pad 2: outer grid rings see only padding
    configure(8'd3, 8'd3, 8'd1, 8'd2, 8'd1, 1'b0);
    pool_query(8'd0, 8'd0);
    pool_query(8'd6, 8'd6);
    pool_query(8'd2, 8'd2);

    // kernel bigger than the padded plane: empty grid
    configure(8'd3, 8'd3, 8'd16, 8'd0, 8'd1, 1'b0);
    pool_query(8'd0, 8'd0);

    // every register out of range, clamped on use; plus an unused index
    configure(8'd0, 8'd255, 8'd0, 8'd31, 8'd0, 1'b1);
    pool_query(8'd16, 8'd16);
    pool_query(8'd0, 8'd159);                       // window right of the plane
    configure(8'd255, 8'd0, 8'd31, 8'd0, 8'd31, 1'b1);
    pool_query(8'd0, 8'd0);                         // one-column plane, empty grid

    // random shapes, each phase a mix of filled queries, writes and noise
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      configure(pick_dim(), pick_dim(), pick_field(1, MAX_KERNEL, 5),
                pick_field(0, PAD_LIMIT, 3), pick_field(1, STRIDE_LIMIT, 4),
                $urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) random_action();
    end

    // drain: every query answered, then room for a stray late result
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/mpool_pkg.sv
sv/max_pool_2d_window_core.sv
test/pool_result_checker.sv
test/tb.sv
